[hdl/plb_pkg.sv]
`default_nettype none
package plb_pkg;
    localparam int unsigned ValW   = 63;
    localparam int unsigned TimeW  = 48;
    localparam int unsigned SlotW  = 5;

    typedef logic [ValW-1:0]  val_t;
    typedef logic [TimeW-1:0] time_t;
    typedef logic [SlotW-1:0] slot_t;

    typedef struct packed {
        logic  side;
        val_t  price;
        val_t  qty;
        logic  has_time;
        time_t event_time;
        logic  end_of_message;
    } upd_t;

    typedef struct packed {
        slot_t slot;
        val_t  slot_price;
        val_t  slot_qty;
        time_t stamp;
        logic  overflowed;
        logic  final_slot;
    } snap_t;
endpackage
`default_nettype wire

[hdl/plb_if.sv]
`default_nettype none
interface plb_upd_if;
    logic          valid;
    logic          ready;
    plb_pkg::upd_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface plb_snap_if;
    logic           valid;
    logic           ready;
    plb_pkg::snap_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hdl/price_level_book_top_snapshot.sv]
`default_nettype none
// Price-level book with top-of-book snapshot.
// Input channel upd (plb_upd_if sink): one level update per word: side, price,
// qty (zero deletes), optional timestamp, end_of_message flag.
// Output channel snap (plb_snap_if source): on an update flagged end_of_message,
// 2*TOP_DEPTH words follow: best bids in slots 0..TOP_DEPTH-1, best asks after;
// empty slots read zero.
// The front accepts a word into a two-entry queue each cycle it has room. The
// back engine takes one update at a time: it pops it from the queue in S_TAKE,
// then applies it in S_APPLY in a row of compare-and-shift cells, and pops no
// new update until it is through. A snapshot emits its slot words in S_SNAP
// after S_APPLY, each slot word in turn into the output register.
// The engine holds while the output register is full and not taken; the queue
// then fills and ready drops.
// Reset empties both tables, clears the timestamp and the drop flag; no
// clearing pass is needed.
module price_level_book_top_snapshot #(
    parameter int unsigned LEVELS    = 64,
    parameter int unsigned TOP_DEPTH = 10
) (
    input wire logic clk,
    input wire logic rst_n,
    plb_upd_if.sink    upd,
    plb_snap_if.source snap
);
    localparam int unsigned IW    = $clog2(LEVELS);
    localparam int unsigned KW    = $clog2(2 * TOP_DEPTH);
    localparam int unsigned TOTAL = 2 * TOP_DEPTH;

    typedef enum logic [1:0] { S_TAKE, S_APPLY, S_SNAP } st_t;

    st_t                  st_reg;
    plb_pkg::upd_t        q_data, cur_reg;
    logic                 q_full, q_empty, q_pop;
    logic [KW-1:0]        k_reg;
    plb_pkg::time_t       stamp_reg;
    logic                 drop_reg;
    logic                 ov_reg;
    plb_pkg::snap_t       out_reg;
    logic                 outv_reg;
    logic                 outv_next;

    plb_fifo u_fifo (
        .clk, .rst_n,
        .push (upd.valid), .wdata (upd.data), .full (q_full),
        .pop (q_pop), .rdata (q_data), .empty (q_empty)
    );
    assign upd.ready = !q_full;
    assign q_pop     = (st_reg == S_TAKE) && !q_empty;

    logic bid_upd, ask_upd, bid_drop, ask_drop;
    logic bid_ok, ask_ok;
    plb_pkg::val_t bid_p, bid_q, ask_p, ask_q;
    logic is_bid;
    logic [KW-1:0] pos;
    logic [IW-1:0] rd_idx;

    assign bid_upd = (st_reg == S_APPLY) && !cur_reg.side;
    assign ask_upd = (st_reg == S_APPLY) && cur_reg.side;
    assign is_bid  = (32'(k_reg) < TOP_DEPTH);
    assign pos     = is_bid ? k_reg : KW'(32'(k_reg) - TOP_DEPTH);
    // positions beyond the table are empty
    logic pos_in;
    assign pos_in = (32'(pos) < LEVELS);
    assign rd_idx = pos_in ? IW'(pos) : '0;

    plb_side #(.LEVELS(LEVELS), .ASK(1'b0)) u_bid (
        .clk, .rst_n, .upd (bid_upd), .price (cur_reg.price), .qty (cur_reg.qty),
        .dropped (bid_drop), .rd_idx (rd_idx), .rd_price (bid_p), .rd_qty (bid_q),
        .rd_ok (bid_ok)
    );
    plb_side #(.LEVELS(LEVELS), .ASK(1'b1)) u_ask (
        .clk, .rst_n, .upd (ask_upd), .price (cur_reg.price), .qty (cur_reg.qty),
        .dropped (ask_drop), .rd_idx (rd_idx), .rd_price (ask_p), .rd_qty (ask_q),
        .rd_ok (ask_ok)
    );

    logic out_free;
    assign out_free  = !outv_reg || snap.ready;
    assign outv_next = (st_reg == S_SNAP && out_free) ? 1'b1
                     : (snap.ready ? 1'b0 : outv_reg);

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (st_reg == S_SNAP && out_free)
        begin
            out_reg.slot       <= plb_pkg::SlotW'(k_reg);
            out_reg.slot_price <= (pos_in && (is_bid ? bid_ok : ask_ok))
                                  ? (is_bid ? bid_p : ask_p) : '0;
            out_reg.slot_qty   <= (pos_in && (is_bid ? bid_ok : ask_ok))
                                  ? (is_bid ? bid_q : ask_q) : '0;
            out_reg.stamp      <= stamp_reg;
            out_reg.overflowed <= ov_reg;
            out_reg.final_slot <= (32'(k_reg) == TOTAL - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_TAKE;
            k_reg     <= '0;
            stamp_reg <= '0;
            drop_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            outv_reg <= outv_next;
            unique case (st_reg)
                S_TAKE:
                begin
                    if (!q_empty)
                    begin
                        st_reg <= S_APPLY;
                        if (q_data.has_time)
                        begin
                            stamp_reg <= q_data.event_time;
                        end
                    end
                end
                S_APPLY:
                begin
                    k_reg <= '0;
                    if (cur_reg.end_of_message)
                    begin
                        // latch flag for the whole snapshot, restart drop tracking
                        ov_reg   <= drop_reg || bid_drop || ask_drop;
                        drop_reg <= 1'b0;
                        st_reg   <= S_SNAP;
                    end
                    else
                    begin
                        drop_reg <= drop_reg || bid_drop || ask_drop;
                        st_reg   <= S_TAKE;
                    end
                end
                S_SNAP:
                begin
                    if (out_free)
                    begin
                        k_reg <= k_reg + 1'b1;
                        if (32'(k_reg) == TOTAL - 1)
                        begin
                            st_reg <= S_TAKE;
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_TAKE;
                end
            endcase
        end
    end

    assign snap.valid = outv_reg;
    assign snap.data  = out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        outv_reg && !snap.ready |=> outv_reg && $stable(out_reg))
        else $error("output word lost under stall");
    a_no_apply_in_snap: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_SNAP |-> !bid_upd && !ask_upd)
        else $error("table updated during snapshot");
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        snap.valid && snap.data.final_slot |-> snap.data.slot == plb_pkg::SlotW'(TOTAL - 1))
        else $error("final flag on wrong slot");
endmodule
`default_nettype wire

[hdl/plb_fifo.sv]
`default_nettype none
// Two-entry queue between the front and the book engine.
module plb_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire plb_pkg::upd_t wdata,
    output logic               full,
    input  wire logic          pop,
    output plb_pkg::upd_t      rdata,
    output logic               empty
);
    plb_pkg::upd_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

    property p_no_wrap;
        @(posedge clk) disable iff (!rst_n) full |=> cnt_reg != 2'd0 || $past(pop);
    endproperty
    a_no_wrap: assert property (p_no_wrap) else $error("fifo emptied without pop");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("fifo count out of range");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'd2) |-> wp_reg == rp_reg)
        else $error("fifo pointers disagree with count");
endmodule
`default_nettype wire

[hdl/plb_side.sv]
`default_nettype none
// One sorted table as a row of compare-and-shift cells. Entry 0 is best.
module plb_side #(
    parameter int unsigned LEVELS  = 64,
    parameter bit          ASK     = 1'b0
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      upd,
    input  wire plb_pkg::val_t             price,
    input  wire plb_pkg::val_t             qty,
    output logic                           dropped,
    input  wire logic [$clog2(LEVELS)-1:0] rd_idx,
    output plb_pkg::val_t                  rd_price,
    output plb_pkg::val_t                  rd_qty,
    output logic                           rd_ok
);
    localparam int unsigned CW = $clog2(LEVELS + 1);

    plb_pkg::val_t pr_reg [LEVELS];
    plb_pkg::val_t qt_reg [LEVELS];
    logic [LEVELS-1:0] v_reg;

    logic [LEVELS-1:0] hit, ahead, from_hit, v_next;
    logic any_hit, del;

    // Valid bits form a prefix; each cell compares the key on its own.
    always_comb
    begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            hit[i]   = v_reg[i] && (pr_reg[i] == price);
            ahead[i] = !v_reg[i] || (ASK ? (price < pr_reg[i]) : (price > pr_reg[i]));
            seen        = seen || hit[i];
            from_hit[i] = seen;
        end
    end
    assign any_hit = |hit;
    assign del     = (qty == '0);
    assign dropped = upd && !del && !any_hit && v_reg[LEVELS-1];

    always_comb
    begin
        v_next = v_reg;
        if (upd && del && any_hit)
        begin
            v_next = {1'b0, v_reg[LEVELS-1:1]};
        end
        else if (upd && !del && !any_hit)
        begin
            v_next = {v_reg[LEVELS-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                if (del)
                begin
                    // shift up from the matching cell on
                    if (from_hit[i] && i < LEVELS - 1)
                    begin
                        pr_reg[i] <= pr_reg[(i < LEVELS - 1) ? i + 1 : i];
                        qt_reg[i] <= qt_reg[(i < LEVELS - 1) ? i + 1 : i];
                    end
                end
                else if (any_hit)
                begin
                    if (hit[i])
                    begin
                        qt_reg[i] <= qty;
                    end
                end
                else if (ahead[i])
                begin
                    if (i == 0 || !ahead[(i > 0) ? i - 1 : 0])
                    begin
                        pr_reg[i] <= price;
                        qt_reg[i] <= qty;
                    end
                    else
                    begin
                        pr_reg[i] <= pr_reg[(i > 0) ? i - 1 : 0];
                        qt_reg[i] <= qt_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
        end
    end

    assign rd_ok    = v_reg[rd_idx];
    assign rd_price = rd_ok ? pr_reg[rd_idx] : '0;
    assign rd_qty   = rd_ok ? qt_reg[rd_idx] : '0;

    logic [CW-1:0] n;
    assign n = CW'($countones(v_reg));
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] || v_reg == '0) else $error("valid bits not a prefix");
    a_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(v_reg)) else $error("table changed without update");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        n <= CW'(LEVELS)) else $error("level count too large");
endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
    localparam int LEVELS = 64;
    localparam int TOP_DEPTH = 10;
    localparam int N_SLOTS = 2 * TOP_DEPTH;

    logic clk;
    logic rst_n;

    plb_upd_if  upd ();
    plb_snap_if snap ();

    price_level_book_top_snapshot #(.LEVELS(LEVELS), .TOP_DEPTH(TOP_DEPTH)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .snap  (snap)
    );

    // book copy held by the predictor
    plb_pkg::val_t  bid_px [LEVELS];
    plb_pkg::val_t  bid_q  [LEVELS];
    int             bid_n;
    plb_pkg::val_t  ask_px [LEVELS];
    plb_pkg::val_t  ask_q  [LEVELS];
    int             ask_n;
    plb_pkg::time_t cur_stamp;
    logic           dropped;

    plb_pkg::upd_t  pending_words [$];
    plb_pkg::snap_t expected_slots [$];
    int             fail_count;
    bit             stim_done;
    bit             hold_off;

    // price pools so updates hit existing levels often
    plb_pkg::val_t  bid_pool [$];
    plb_pkg::val_t  ask_pool [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit better(logic sd, plb_pkg::val_t a, plb_pkg::val_t b);
        return sd ? (a < b) : (a > b);
    endfunction

    task automatic apply_level(logic sd, plb_pkg::val_t px, plb_pkg::val_t q);
        plb_pkg::val_t tp [LEVELS];
        plb_pkg::val_t tq [LEVELS];
        int   n;
        int   i;
        int   j;
        bit   hit;
        if (sd)
        begin
            tp = ask_px; tq = ask_q; n = ask_n;
        end
        else
        begin
            tp = bid_px; tq = bid_q; n = bid_n;
        end
        hit = 0;
        if (q == '0)
        begin
            for (i = 0; i < n && !hit; i++)
                if (tp[i] == px)
                begin
                    for (j = i; j < n - 1; j++)
                    begin
                        tp[j] = tp[j+1]; tq[j] = tq[j+1];
                    end
                    n--;
                    hit = 1;
                end
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                if (tp[i] == px)
                begin
                    tq[i] = q;
                    hit = 1;
                    break;
                end
                if (better(sd, px, tp[i]))
                    break;
            end
            if (!hit)
            begin
                if (n == LEVELS)
                begin
                    dropped = 1'b1;
                    n = LEVELS - 1;
                end
                if (i < LEVELS)
                begin
                    for (j = n; j > i; j--)
                    begin
                        tp[j] = tp[j-1]; tq[j] = tq[j-1];
                    end
                    tp[i] = px; tq[i] = q;
                    n++;
                end
                else
                    n = LEVELS;
            end
        end
        if (sd)
        begin
            ask_px = tp; ask_q = tq; ask_n = n;
        end
        else
        begin
            bid_px = tp; bid_q = tq; bid_n = n;
        end
    endtask

    task automatic predict_book(plb_pkg::upd_t w);
        plb_pkg::snap_t s;
        int    k;
        int    pos;
        if (w.has_time)
            cur_stamp = w.event_time;
        apply_level(w.side, w.price, w.qty);
        if (!w.end_of_message)
            return;
        for (k = 0; k < N_SLOTS; k++)
        begin
            s.slot = plb_pkg::slot_t'(k);
            s.slot_price = '0;
            s.slot_qty = '0;
            if (k < TOP_DEPTH)
            begin
                if (k < bid_n)
                begin
                    s.slot_price = bid_px[k]; s.slot_qty = bid_q[k];
                end
            end
            else
            begin
                pos = k - TOP_DEPTH;
                if (pos < ask_n)
                begin
                    s.slot_price = ask_px[pos]; s.slot_qty = ask_q[pos];
                end
            end
            s.stamp = cur_stamp;
            s.overflowed = dropped;
            s.final_slot = (k == N_SLOTS - 1);
            expected_slots.push_back(s);
        end
        dropped = 1'b0;
    endtask

    function automatic plb_pkg::val_t rand_val();
        return plb_pkg::val_t'({$urandom, $urandom});
    endfunction

    function automatic plb_pkg::upd_t make_word(logic sd, plb_pkg::val_t px,
                                                plb_pkg::val_t q, logic eom);
        plb_pkg::upd_t w;
        w.side = sd;
        w.price = px;
        w.qty = q;
        w.has_time = 1'($urandom_range(0, 1));
        w.event_time = plb_pkg::time_t'({$urandom, $urandom});
        w.end_of_message = eom;
        return w;
    endfunction

    task automatic queue_word(plb_pkg::upd_t w);
        pending_words.push_back(w);
        if (w.qty != '0)
        begin
            if (w.side) ask_pool.push_back(w.price);
            else        bid_pool.push_back(w.price);
        end
    endtask

    function automatic plb_pkg::val_t pick_price(logic sd);
        int r;
        r = $urandom_range(0, 9);
        if (sd && ask_pool.size() > 0 && r < 5)
            return ask_pool[$urandom_range(0, ask_pool.size() - 1)];
        if (!sd && bid_pool.size() > 0 && r < 5)
            return bid_pool[$urandom_range(0, bid_pool.size() - 1)];
        if (r < 8)
            return plb_pkg::val_t'($urandom_range(1000, 1200));
        return rand_val();
    endfunction

    // stimulus
    initial
    begin
        int i;
        logic sd;
        plb_pkg::val_t q;
        // extremes, delete of absent, overwrite, delete of present
        queue_word(make_word(1'b0, '0, '0, 1'b1));
        queue_word(make_word(1'b0, {63{1'b1}}, {63{1'b1}}, 1'b0));
        queue_word(make_word(1'b1, {63{1'b1}}, 63'd1, 1'b0));
        queue_word(make_word(1'b1, '0, {63{1'b1}}, 1'b1));
        queue_word(make_word(1'b0, 63'd500, 63'd7, 1'b0));
        queue_word(make_word(1'b0, 63'd500, 63'd9, 1'b1));
        queue_word(make_word(1'b1, 63'd12345, '0, 1'b1));
        queue_word(make_word(1'b0, {63{1'b1}}, '0, 1'b1));
        queue_word(make_word(1'b1, 63'h2AAAAAAAAAAAAAAA, 63'h5555555555555555, 1'b1));
        // fill the bid table past its depth to force drops both ways
        for (i = 0; i < LEVELS + 4; i++)
            queue_word(make_word(1'b0, plb_pkg::val_t'(2000 + 3 * i), 63'd1, 1'b0));
        queue_word(make_word(1'b0, 63'd5, 63'd3, 1'b1));
        queue_word(make_word(1'b0, 63'd9000, 63'd3, 1'b1));
        for (i = 0; i < 40; i++)
        begin
            sd = 1'($urandom_range(0, 1));
            q = ($urandom_range(0, 3) == 0) ? plb_pkg::val_t'(0) : rand_val();
            queue_word(make_word(sd, pick_price(sd), q, $urandom_range(0, 5) == 0));
        end
        queue_word(make_word(1'b1, 63'd77, 63'd1, 1'b1));
    end

    // acceptance sampled at rising edge, consumed at next falling edge
    logic accepted_in;

    // driver: bursts with gaps, update at falling edge
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd.valid <= 1'b0;
            upd.data <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!upd.valid || accepted_in)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                upd.valid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 12);
                upd.data <= pending_words.pop_front();
                upd.valid <= 1'b1;
                burst_left--;
                if (burst_left == 0)
                    gap_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            end
            else
            begin
                upd.valid <= 1'b0;
                stim_done = 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accepted_in <= 1'b0;
        else
        begin
            accepted_in <= upd.valid && upd.ready;
            if (upd.valid && upd.ready)
                predict_book(upd.data);
        end
    end

    // receiver stall pattern plus one long hold-off
    int stall_phase;
    int hold_cnt;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap.ready <= 1'b0;
            stall_phase = 0;
            hold_cnt = 0;
        end
        else
        begin
            stall_phase++;
            if (hold_off)
            begin
                hold_cnt++;
                snap.ready <= 1'b0;
                if (hold_cnt >= 300)
                    hold_off = 1'b0;
            end
            else if (stall_phase < 400)
                snap.ready <= 1'b1;
            else
                snap.ready <= ((stall_phase % 7) < 4) && ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (150) @(posedge clk);
        hold_off = 1'b1;
    end

    // monitor
    always @(posedge clk)
    begin
        plb_pkg::snap_t e;
        if (rst_n && snap.valid && snap.ready)
        begin
            if (expected_slots.size() == 0)
            begin
                $display("%0t: unexpected snapshot word %p", $time, snap.data);
                fail_count++;
            end
            else
            begin
                e = expected_slots.pop_front();
                if (snap.data.slot !== e.slot)
                begin
                    $display("%0t: slot exp %0d got %0d", $time, e.slot, snap.data.slot);
                    fail_count++;
                end
                if (snap.data.slot_price !== e.slot_price)
                begin
                    $display("%0t: slot_price exp %0d got %0d", $time, e.slot_price,
                        snap.data.slot_price);
                    fail_count++;
                end
                if (snap.data.slot_qty !== e.slot_qty)
                begin
                    $display("%0t: slot_qty exp %0d got %0d", $time, e.slot_qty,
                        snap.data.slot_qty);
                    fail_count++;
                end
                if (snap.data.stamp !== e.stamp)
                begin
                    $display("%0t: stamp exp %0d got %0d", $time, e.stamp, snap.data.stamp);
                    fail_count++;
                end
                if (snap.data.overflowed !== e.overflowed)
                begin
                    $display("%0t: overflowed exp %0b got %0b", $time, e.overflowed,
                        snap.data.overflowed);
                    fail_count++;
                end
                if (snap.data.final_slot !== e.final_slot)
                begin
                    $display("%0t: final_slot exp %0b got %0b", $time, e.final_slot,
                        snap.data.final_slot);
                    fail_count++;
                end
            end
        end
    end

    // reset and end of run
    initial
    begin
        fail_count = 0;
        stim_done = 1'b0;
        bid_n = 0;
        ask_n = 0;
        cur_stamp = '0;
        dropped = 1'b0;
        rst_n = 1'b0;
        upd.valid = 1'b0;
        upd.data = '0;
        snap.ready = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stim_done && !upd.valid && expected_slots.size() == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && expected_slots.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[price_level_book_top_snapshot.f]
hdl/plb_pkg.sv
hdl/plb_if.sv
hdl/plb_fifo.sv
hdl/plb_side.sv
hdl/price_level_book_top_snapshot.sv
tb/tb_top.sv
